### rtl/core/tickless_alarm_timer_core_macros.svh
// assertion macros for the tickless alarm timer core
`ifndef TICKLESS_ALARM_TIMER_CORE_MACROS_SVH
`define TICKLESS_ALARM_TIMER_CORE_MACROS_SVH

`ifndef SYNTH
// same-cycle implication, disabled in reset
`define TAT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tat assertion failed");
// next-cycle implication, disabled in reset
`define TAT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tat assertion failed");
`else
`define TAT_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define TAT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### rtl/core/tat_pkg.sv
package tat_pkg;

    // operation codes
    localparam logic [1:0] OP_SET_ALARM   = 2'd0;
    localparam logic [1:0] OP_ABORT_ALARM = 2'd1;
    localparam logic [1:0] OP_PERIOD_EXP  = 2'd2;
    localparam logic [1:0] OP_READ_TICK   = 2'd3;

    // queue geometry, shared by the command and result queues
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);
    localparam logic [Q_CNT_W-1:0] Q_FULL_CNT = Q_CNT_W'(Q_DEPTH);

    localparam logic [31:0] MAX_PERIOD_RST = 32'hFFFF_FFFF;

    // classified operation, one-hot kind plus operands
    typedef struct packed {
        logic        set_alarm;
        logic        abort_alarm;
        logic        period_exp;
        logic        read_tick;
        logic [63:0] alarm_tick;
        logic [31:0] hw_elapsed;
    } t_cmd;

    // one result word
    typedef struct packed {
        logic        period_written;
        logic [31:0] new_period;
        logic [63:0] current_tick;
        logic [63:0] pending_alarm;
        logic        alarm_fired;
        logic        rejected;
    } t_res;

endpackage

### rtl/core/tat_front.sv
`include "tickless_alarm_timer_core_macros.svh"

module tat_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  logic [1:0]         i_opcode,
    input  logic [63:0]        i_alarm_tick,
    input  logic [31:0]        i_hw_elapsed,
    output logic               o_cmd_valid,
    output tat_pkg::t_cmd      o_cmd,
    input  logic               i_cmd_take
);
    import tat_pkg::*;

    t_cmd               r_q [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [Q_CNT_W-1:0] r_cnt, n_cnt;
    t_cmd               dec_cmd;
    logic               do_push;
    logic               do_take;

    // classify the incoming word
    always_comb begin
        dec_cmd             = '0;
        dec_cmd.alarm_tick  = i_alarm_tick;
        dec_cmd.hw_elapsed  = i_hw_elapsed;
        unique case (i_opcode)
            OP_SET_ALARM:   dec_cmd.set_alarm   = 1'b1;
            OP_ABORT_ALARM: dec_cmd.abort_alarm = 1'b1;
            OP_PERIOD_EXP:  dec_cmd.period_exp  = 1'b1;
            OP_READ_TICK:   dec_cmd.read_tick   = 1'b1;
            default:        dec_cmd.read_tick   = 1'b1;
        endcase
    end

    // command queue handshakes
    assign o_full      = (r_cnt == Q_FULL_CNT);
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rd_ptr];
    assign do_push     = i_push && !o_full;
    assign do_take     = i_cmd_take && o_cmd_valid;

    // pointer and count update
    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = do_take ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_cnt    = r_cnt;
        if (do_push && !do_take) begin
            n_cnt = r_cnt + Q_CNT_W'(1);
        end else if (!do_push && do_take) begin
            n_cnt = r_cnt - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wr_ptr] <= dec_cmd;
        end
    end

    `TAT_ASSERT_IMPL(a_front_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= Q_FULL_CNT)
    `TAT_ASSERT_NEXT(a_front_cnt_grow, i_clk, i_rst_n, do_push && !do_take, r_cnt != '0)

endmodule

### rtl/core/tat_back.sv
`include "tickless_alarm_timer_core_macros.svh"

module tat_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [31:0]        i_cfg_wdata,
    input  logic               i_cmd_valid,
    input  tat_pkg::t_cmd      i_cmd,
    output logic               o_cmd_take,
    output logic               o_empty,
    input  logic               i_pop,
    output tat_pkg::t_res      o_res
);
    import tat_pkg::*;

    // timer state
    logic [31:0] r_max_period;
    logic [63:0] r_base, n_base;
    logic [63:0] r_alarm_at, n_alarm_at;
    logic [63:0] r_rem, n_rem;
    logic [31:0] r_period, n_period;

    // result queue
    t_res               r_q [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_cnt;

    logic        do_pop;
    logic        exec;
    logic        pending;
    logic [63:0] base_el;
    logic [63:0] base_per;
    logic [63:0] set_rem;
    logic [63:0] exp_rem;
    logic [63:0] max_ext;
    t_res        res;

    assign o_empty    = (r_cnt == '0);
    assign o_res      = r_q[r_rd_ptr];
    assign do_pop     = i_pop && !o_empty;
    assign exec       = i_cmd_valid && ((r_cnt != Q_FULL_CNT) || do_pop);
    assign o_cmd_take = exec;

    // shared arithmetic
    assign pending  = (r_alarm_at != '0);
    assign base_el  = r_base + {32'b0, i_cmd.hw_elapsed};
    assign base_per = r_base + {32'b0, r_period};
    assign set_rem  = i_cmd.alarm_tick - base_el;
    assign exp_rem  = r_rem - {32'b0, r_period};
    assign max_ext  = {32'b0, r_max_period};

    // operation execution
    always_comb begin
        n_base     = r_base;
        n_alarm_at = r_alarm_at;
        n_rem      = r_rem;
        n_period   = r_period;
        res        = '0;
        if (i_cmd.set_alarm) begin
            if (!pending || (i_cmd.alarm_tick < r_alarm_at)) begin
                n_base             = base_el;
                n_alarm_at         = i_cmd.alarm_tick;
                n_rem              = set_rem;
                n_period           = (set_rem > max_ext) ? r_max_period : set_rem[31:0];
                res.period_written = 1'b1;
            end else begin
                res.rejected = 1'b1;
            end
        end else if (i_cmd.abort_alarm) begin
            if (pending) begin
                n_base             = base_el;
                n_period           = r_max_period;
                n_alarm_at         = '0;
                res.period_written = 1'b1;
            end
        end else if (i_cmd.period_exp) begin
            n_base             = base_per;
            res.period_written = 1'b1;
            if (!pending) begin
                n_period = r_max_period;
            end else begin
                n_rem = exp_rem;
                if (exp_rem == '0) begin
                    n_period        = r_max_period;
                    n_alarm_at      = '0;
                    res.alarm_fired = 1'b1;
                end else begin
                    n_period = (exp_rem > max_ext) ? r_max_period : exp_rem[31:0];
                end
            end
        end else begin
            res.current_tick = base_el;
        end
        res.new_period    = n_period;
        res.pending_alarm = n_alarm_at;
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_period <= MAX_PERIOD_RST;
            r_base       <= '0;
            r_alarm_at   <= '0;
            r_rem        <= '0;
            r_period     <= MAX_PERIOD_RST;
        end else begin
            if (i_cfg_we) begin
                r_max_period <= i_cfg_wdata;
            end
            if (exec) begin
                r_base     <= n_base;
                r_alarm_at <= n_alarm_at;
                r_rem      <= n_rem;
                r_period   <= n_period;
            end
        end
    end

    // result queue control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (exec) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (exec && !do_pop) begin
                r_cnt <= r_cnt + Q_CNT_W'(1);
            end else if (!exec && do_pop) begin
                r_cnt <= r_cnt - Q_CNT_W'(1);
            end
        end
    end

    // result storage
    always_ff @(posedge i_clk) begin
        if (exec) begin
            r_q[r_wr_ptr] <= res;
        end
    end

    // remaining ticks always track alarm minus base while an alarm is pending
    `TAT_ASSERT_IMPL(a_rem_tracks_alarm, i_clk, i_rst_n, r_alarm_at != '0,
                     r_rem == r_alarm_at - r_base)
    `TAT_ASSERT_IMPL(a_res_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= Q_FULL_CNT)
    `TAT_ASSERT_NEXT(a_exp_adv_base, i_clk, i_rst_n, exec && i_cmd.period_exp, r_base == $past(base_per))
    `TAT_ASSERT_NEXT(a_fire_clears, i_clk, i_rst_n, exec && res.alarm_fired, r_alarm_at == '0)

endmodule

### rtl/core/tickless_alarm_timer_core.sv
// channel   | direction | handshake              | words
// ----------+-----------+------------------------+------------------------------------------
// input     | in        | push / full            | i_opcode, i_alarm_tick, i_hw_elapsed
// result    | out       | empty / pop            | o_period_written .. o_rejected
// config    | in        | i_cfg_we               | i_cfg_wdata (max_period)
//
// one word per cycle sustained while the result queue is popped; an accepted word is
// registered in the command queue, then executed and registered in the result queue
// the rate is set by the execute stage holding the 64-bit timer state
// reset clears both queues and the timer state, period and max period return to all ones
// a stalled pop fills the two-entry result queue, then the two-entry command queue,
// then full rises

module tickless_alarm_timer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_opcode,
    input  logic [63:0] i_alarm_tick,
    input  logic [31:0] i_hw_elapsed,
    output logic        empty,
    input  logic        pop,
    output logic        o_period_written,
    output logic [31:0] o_new_period,
    output logic [63:0] o_current_tick,
    output logic [63:0] o_pending_alarm,
    output logic        o_alarm_fired,
    output logic        o_rejected,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata
);
    import tat_pkg::*;

    logic cmd_valid;
    logic cmd_take;
    t_cmd cmd;
    t_res res;

    // front: accept and classify
    tat_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_opcode     (i_opcode),
        .i_alarm_tick (i_alarm_tick),
        .i_hw_elapsed (i_hw_elapsed),
        .o_cmd_valid  (cmd_valid),
        .o_cmd        (cmd),
        .i_cmd_take   (cmd_take)
    );

    // back: execute and queue results
    tat_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_take  (cmd_take),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_res       (res)
    );

    // result word fan-out
    assign o_period_written = res.period_written;
    assign o_new_period     = res.new_period;
    assign o_current_tick   = res.current_tick;
    assign o_pending_alarm  = res.pending_alarm;
    assign o_alarm_fired    = res.alarm_fired;
    assign o_rejected       = res.rejected;

endmodule

### tb/tickless_alarm_timer_core_tb.sv
`timescale 1ns / 100ps

module tickless_alarm_timer_core_tb;
    import tat_pkg::*;

    localparam int N_PHASES      = 8;
    localparam int WORDS_PER_PHS = 182;
    localparam int SETTLE_CYCLES = 6;

    // directed stimulus row, want is used only where fixed is set
    typedef struct {
        logic [1:0]  op;
        logic [63:0] tick;
        logic [31:0] el;
        bit          fixed;
        t_res        want;
    } t_dir_row;

    logic        i_clk;
    logic        i_rst_n      = 1'b0;
    logic        push         = 1'b0;
    logic        full;
    logic [1:0]  i_opcode     = OP_READ_TICK;
    logic [63:0] i_alarm_tick = '0;
    logic [31:0] i_hw_elapsed = '0;
    logic        empty;
    logic        pop          = 1'b0;
    logic        o_period_written;
    logic [31:0] o_new_period;
    logic [63:0] o_current_tick;
    logic [63:0] o_pending_alarm;
    logic        o_alarm_fired;
    logic        o_rejected;
    logic        i_cfg_we     = 1'b0;
    logic [31:0] i_cfg_wdata  = '0;

    // timer state as the block should hold it
    logic [63:0] base_cnt;
    logic [63:0] alarm_due;
    logic [63:0] ticks_left;
    logic [31:0] period_cur;
    logic [31:0] period_cap;

    t_res timer_words_due[$];
    int   n_fail = 0;

    // max period settings, one per random phase; the last phase may take a random value instead
    logic [31:0] cap_list [0:N_PHASES-1] = '{
        32'hFFFF_FFFF, 32'd1, 32'd7, 32'd0,
        32'd64, 32'h8000_0000, 32'h0000_1000, 32'hFFFF_FFFE
    };

    t_dir_row dir_rows [0:18] = '{
        // read after reset
        '{OP_READ_TICK, 64'd0, 32'd0, 1'b1,
          {1'b0, 32'hFFFF_FFFF, 64'd0, 64'd0, 1'b0, 1'b0}},
        '{OP_READ_TICK, 64'd0, 32'hFFFF_FFFF, 1'b1,
          {1'b0, 32'hFFFF_FFFF, 64'h0000_0000_FFFF_FFFF, 64'd0, 1'b0, 1'b0}},
        // abort with nothing pending
        '{OP_ABORT_ALARM, 64'd0, 32'd5, 1'b1,
          {1'b0, 32'hFFFF_FFFF, 64'd0, 64'd0, 1'b0, 1'b0}},
        // expiry with no alarm
        '{OP_PERIOD_EXP, 64'd0, 32'd0, 1'b1,
          {1'b1, 32'hFFFF_FFFF, 64'd0, 64'd0, 1'b0, 1'b0}},
        // alarm at the base tick, then it fires
        '{OP_SET_ALARM, 64'h0000_0000_FFFF_FFFF, 32'd0, 1'b0, '0},
        '{OP_PERIOD_EXP, 64'd0, 32'd0, 1'b0, '0},
        // alarm tick zero
        '{OP_SET_ALARM, 64'd0, 32'd7, 1'b0, '0},
        // alarm in the past
        '{OP_SET_ALARM, 64'd5, 32'd0, 1'b0, '0},
        // later alarm refused
        '{OP_SET_ALARM, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 1'b1,
          {1'b0, 32'hFFFF_FFFF, 64'd0, 64'd5, 1'b0, 1'b1}},
        // earlier alarm taken
        '{OP_SET_ALARM, 64'd4, 32'd0, 1'b0, '0},
        // abort with an alarm pending
        '{OP_ABORT_ALARM, 64'd0, 32'd3, 1'b0, '0},
        '{OP_SET_ALARM, 64'h0000_0002_0000_0010, 32'h10, 1'b0, '0},
        '{OP_PERIOD_EXP, 64'd0, 32'd0, 1'b0, '0},
        // far alarm, one period of its countdown, then an earlier alarm and an abort
        '{OP_SET_ALARM, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0},
        '{OP_PERIOD_EXP, 64'd0, 32'd0, 1'b0, '0},
        '{OP_READ_TICK, 64'd0, 32'h1234_5678, 1'b0, '0},
        '{OP_SET_ALARM, 64'hFFFF_FFFF_FFFF_FFFE, 32'd0, 1'b0, '0},
        '{OP_ABORT_ALARM, 64'd0, 32'd0, 1'b0, '0},
        '{OP_READ_TICK, 64'd0, 32'hFFFF_FFFF, 1'b0, '0}
    };

    tickless_alarm_timer_core u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_opcode         (i_opcode),
        .i_alarm_tick     (i_alarm_tick),
        .i_hw_elapsed     (i_hw_elapsed),
        .empty            (empty),
        .pop              (pop),
        .o_period_written (o_period_written),
        .o_new_period     (o_new_period),
        .o_current_tick   (o_current_tick),
        .o_pending_alarm  (o_pending_alarm),
        .o_alarm_fired    (o_alarm_fired),
        .o_rejected       (o_rejected),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // period that puts the alarm on a boundary, capped at max period
    function automatic logic [31:0] aligned_period();
        logic [63:0] gap;
        gap = alarm_due - base_cnt;
        if (gap > 64'(period_cap)) begin
            aligned_period = period_cap;
        end else begin
            aligned_period = gap[31:0];
        end
    endfunction

    // apply one operation to the timer state, return the word it yields
    function automatic t_res advance_timer(logic [1:0] op, logic [63:0] tick,
                                           logic [31:0] el);
        t_res r;
        r = '0;
        case (op)
            OP_SET_ALARM: begin
                if (alarm_due == 64'd0 || tick < alarm_due) begin
                    base_cnt   = base_cnt + 64'(el);
                    alarm_due  = tick;
                    ticks_left = alarm_due - base_cnt;
                    period_cur = aligned_period();
                    r.period_written = 1'b1;
                end else begin
                    r.rejected = 1'b1;
                end
            end
            OP_ABORT_ALARM: begin
                if (alarm_due != 64'd0) begin
                    base_cnt   = base_cnt + 64'(el);
                    period_cur = period_cap;
                    alarm_due  = '0;
                    r.period_written = 1'b1;
                end
            end
            OP_PERIOD_EXP: begin
                base_cnt = base_cnt + 64'(period_cur);
                r.period_written = 1'b1;
                if (alarm_due == 64'd0) begin
                    period_cur = period_cap;
                end else begin
                    ticks_left = ticks_left - 64'(period_cur);
                    if (ticks_left == 64'd0) begin
                        period_cur    = period_cap;
                        alarm_due     = '0;
                        r.alarm_fired = 1'b1;
                    end else begin
                        period_cur = aligned_period();
                    end
                end
            end
            default: begin
                r.current_tick = base_cnt + 64'(el);
            end
        endcase
        r.new_period    = period_cur;
        r.pending_alarm = alarm_due;
        return r;
    endfunction

    // alarm tick half the time one to six periods ahead of now, else odd cases
    function automatic logic [63:0] pick_alarm(logic [31:0] el);
        logic [63:0] now;
        now = base_cnt + 64'(el);
        case ($urandom_range(0, 11))
            0: pick_alarm = {$urandom, $urandom};
            1: pick_alarm = '0;
            2: pick_alarm = '1;
            3: pick_alarm = alarm_due - 64'($urandom_range(0, 3));
            4: pick_alarm = now - 64'($urandom_range(1, 100));
            5: pick_alarm = now;
            default: pick_alarm = now + 64'($urandom_range(1, 6)) * 64'(period_cap)
                                      + 64'($urandom_range(0, 3));
        endcase
    endfunction

    // present one word and wait until it is taken
    task automatic send_word(logic [1:0] op, logic [63:0] tick, logic [31:0] el,
                             bit fixed, t_res want);
        t_res predicted;
        @(negedge i_clk);
        push         <= 1'b1;
        i_opcode     <= op;
        i_alarm_tick <= tick;
        i_hw_elapsed <= el;
        do @(posedge i_clk); while (full);
        predicted = advance_timer(op, tick, el);
        timer_words_due.push_back(fixed ? want : predicted);
    endtask

    task automatic idle_push(int n);
        @(negedge i_clk);
        push <= 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    task automatic drain_results();
        while (timer_words_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // max period write, only once the block has gone quiet
    task automatic set_max_period(logic [31:0] v);
        idle_push(1);
        drain_results();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        period_cap = v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // stimulus
    initial begin : stimulus
        int          left;
        int          burst;
        int          pick;
        logic [1:0]  op;
        logic [31:0] el;
        logic [63:0] tick;

        base_cnt   = '0;
        alarm_due  = '0;
        ticks_left = '0;
        period_cap = MAX_PERIOD_RST;
        period_cur = MAX_PERIOD_RST;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            send_word(dir_rows[i].op, dir_rows[i].tick, dir_rows[i].el,
                      dir_rows[i].fixed, dir_rows[i].want);
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            set_max_period((ph == N_PHASES - 1 && $urandom_range(0, 1) == 1) ?
                           $urandom : cap_list[ph]);
            left = WORDS_PER_PHS;
            while (left > 0) begin
                burst = $urandom_range(1, 24);
                while (burst > 0 && left > 0) begin
                    pick = $urandom_range(0, 19);
                    if (pick < 14) begin
                        el = $urandom_range(0, 15);
                    end else if (pick < 17) begin
                        el = $urandom;
                    end else if (pick < 18) begin
                        el = '1;
                    end else begin
                        el = '0;
                    end
                    pick = $urandom_range(0, 99);
                    if (pick < 30) begin
                        op = OP_SET_ALARM;
                    end else if (pick < 40) begin
                        op = OP_ABORT_ALARM;
                    end else if (pick < 82) begin
                        op = OP_PERIOD_EXP;
                    end else begin
                        op = OP_READ_TICK;
                    end
                    tick = (op == OP_SET_ALARM) ? pick_alarm(el) : {$urandom, $urandom};
                    send_word(op, tick, el, 1'b0, '0);
                    burst--;
                    left--;
                end
                // gaps between bursts, some bursts run straight on
                if ($urandom_range(0, 3) != 0) begin
                    idle_push($urandom_range(1, 8));
                end
            end
        end

        idle_push(1);
        drain_results();
        if (n_fail == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // receiver stalls in runs: free flowing, coin toss or mostly held
    initial begin : result_pacing
        int mode;
        int run;
        forever begin
            mode = $urandom_range(0, 2);
            run  = $urandom_range(8, 80);
            repeat (run) begin
                @(negedge i_clk);
                case (mode)
                    0:       pop <= 1'b1;
                    1:       pop <= 1'($urandom_range(0, 1));
                    default: pop <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    task automatic report_field(string name, logic [63:0] due, logic [63:0] got);
        if (due !== got) begin
            $error("%s: expected %h, got %h", name, due, got);
            n_fail++;
        end
    endtask

    // compare each popped word with the oldest one due
    always @(posedge i_clk) begin : result_check
        t_res due;
        if (i_rst_n && pop && !empty) begin
            if (timer_words_due.size() == 0) begin
                $error("result word with nothing due");
                n_fail++;
            end else begin
                due = timer_words_due.pop_front();
                report_field("period_written", 64'(due.period_written),
                             64'(o_period_written));
                report_field("new_period", 64'(due.new_period), 64'(o_new_period));
                report_field("current_tick", due.current_tick, o_current_tick);
                report_field("pending_alarm", due.pending_alarm, o_pending_alarm);
                report_field("alarm_fired", 64'(due.alarm_fired), 64'(o_alarm_fired));
                report_field("rejected", 64'(due.rejected), 64'(o_rejected));
            end
        end
    end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/tat_pkg.sv
rtl/core/tat_front.sv
rtl/core/tat_back.sv
rtl/core/tickless_alarm_timer_core.sv
tb/tickless_alarm_timer_core_tb.sv
